// File: rtl/tasi_pkg.sv
package tasi_pkg;

   // Field and datapath widths
   localparam int CNT_W      = 16;               // axis step counts, move length, index
   localparam int ERR_W      = CNT_W + 1;        // DDA error term, below 2*N
   localparam int HP_W       = 16;               // half period in us
   localparam int LIMIT_W    = 16;
   localparam int GAIN_W     = 12;
   localparam int PROD_W     = 2 * CNT_W;        // i*(N-i) and N*N
   localparam int GP_W       = GAIN_W + PROD_W;  // gain * i*(N-i)
   localparam int QUO_W      = 16;               // dip quotient, always below 2^QUO_W
   localparam int DIV_W      = PROD_W + QUO_W;   // divisor shifted up by QUO_W-1, plus one
   localparam int QCNT_W     = $clog2(QUO_W);
   localparam int DIP_W      = QUO_W + 1;        // quotient plus ceiling carry

   // Stream and register port widths
   localparam int REQ_DATA_W = 56;               // 3 counts + 3 dirs, padded to bytes
   localparam int RSP_DATA_W = 24;               // 3 steps + 3 dirs + half period, padded
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [HP_W-1:0]    BASE_RESET  = 16'd600;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2400;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 12'd2000;

   // Item kinds carried on req_tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_G,
      ST_DIV_SETUP,
      ST_DIV,
      ST_HOLD
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // latch a new move
      logic start;      // advance the index and run the DDA
      logic mul_p;      // p = i*(N-i), N*N
      logic mul_g;      // gain * p
      logic div_init;   // pick dividend and divisor
      logic div_step;   // one quotient bit
      logic out_load;   // move result into the output register
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pending;    // step index below move length
   } dp_status_type;

endpackage

// File: rtl/tasi_ctrl.sv
module tasi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output tasi_pkg::dp_cmd_type   cmd,
   input  tasi_pkg::dp_status_type status
);
   import tasi_pkg::*;

   ctrl_state_type     state_ff, state_in;
   logic [QCNT_W-1:0]  qcnt_ff, qcnt_in;
   logic               valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         qcnt_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         qcnt_ff  <= qcnt_in;
         valid_ff <= valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      qcnt_in    = qcnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else if (status.pending) begin
                  cmd.start = 1'b1;
                  state_in  = ST_MUL_P;
               end
            end
         end
         ST_MUL_P: begin
            cmd.mul_p = 1'b1;
            state_in  = ST_MUL_G;
         end
         ST_MUL_G: begin
            cmd.mul_g = 1'b1;
            state_in  = ST_DIV_SETUP;
         end
         ST_DIV_SETUP: begin
            cmd.div_init = 1'b1;
            qcnt_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            qcnt_in      = qcnt_ff + 1'b1;
            if (qcnt_ff == QCNT_W'(QUO_W - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // wait for the output register to free up
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output valid flag
   always_comb begin
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// File: rtl/tasi_dp.sv
module tasi_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  tasi_pkg::dp_cmd_type                cmd,
   output tasi_pkg::dp_status_type             status,
   input  logic [tasi_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                csr_we,
   input  logic [tasi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tasi_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [tasi_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);
   import tasi_pkg::*;

   // Settings
   logic [HP_W-1:0]    base_ff, base_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;

   // Move state
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   cnt_ff [3];
   logic [CNT_W-1:0]   cnt_in [3];
   logic [ERR_W-1:0]   err_ff [3];
   logic [ERR_W-1:0]   err_in [3];
   logic [2:0]         dir_ff, dir_in;

   // Step result staging and arithmetic
   logic [2:0]         step_ff, step_in;
   logic               last_ff, last_in;
   logic [PROD_W-1:0]  p_ff, p_in;
   logic [PROD_W-1:0]  nsq_ff, nsq_in;
   logic [GP_W-1:0]    gp_ff, gp_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dsh_ff, dsh_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;

   // Output register
   logic [RSP_DATA_W-1:0] out_ff, out_in;
   logic                  olast_ff, olast_in;

   // Load unpacking and helpers
   logic [CNT_W-1:0]   ld_cnt [3];
   logic [CNT_W-1:0]   ld_max;
   logic [CNT_W-1:0]   idx_nxt;
   logic [ERR_W-1:0]   err_sum [3];
   logic               rem_ge;
   logic [DIP_W-1:0]   dip;
   logic [HP_W-1:0]    hp;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         limit_ff <= LIMIT_RESET;
         gain_ff  <= GAIN_RESET;
         n_ff     <= '0;
         idx_ff   <= '0;
         dir_ff   <= '0;
         for (int k = 0; k < 3; k++) begin
            cnt_ff[k] <= '0;
            err_ff[k] <= '0;
         end
      end else begin
         base_ff  <= base_in;
         limit_ff <= limit_in;
         gain_ff  <= gain_in;
         n_ff     <= n_in;
         idx_ff   <= idx_in;
         dir_ff   <= dir_in;
         for (int k = 0; k < 3; k++) begin
            cnt_ff[k] <= cnt_in[k];
            err_ff[k] <= err_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      last_ff  <= last_in;
      p_ff     <= p_in;
      nsq_ff   <= nsq_in;
      gp_ff    <= gp_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      out_ff   <= out_in;
      olast_ff <= olast_in;
   end

   // Register writes; index 3 is ignored
   always_comb begin
      base_in  = base_ff;
      limit_in = limit_ff;
      gain_in  = gain_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BASE:  base_in  = csr_wdata[HP_W-1:0];
            CSR_LIMIT: limit_in = csr_wdata[LIMIT_W-1:0];
            CSR_GAIN:  gain_in  = csr_wdata[GAIN_W-1:0];
            default:   ;
         endcase
      end
   end

   // Load fields: counts in the low 48 bits, directions above
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ld_cnt[k] = req_tdata[k*CNT_W +: CNT_W];
      end
      ld_max = ld_cnt[0];
      if (ld_cnt[1] > ld_max) ld_max = ld_cnt[1];
      if (ld_cnt[2] > ld_max) ld_max = ld_cnt[2];
   end

   assign idx_nxt        = idx_ff + 1'b1;
   assign status.pending = (idx_ff < n_ff);

   // Move state and DDA: err tracks i*count - taken*N, kept below N
   always_comb begin
      n_in    = n_ff;
      idx_in  = idx_ff;
      dir_in  = dir_ff;
      step_in = step_ff;
      last_in = last_ff;
      for (int k = 0; k < 3; k++) begin
         cnt_in[k]  = cnt_ff[k];
         err_in[k]  = err_ff[k];
         err_sum[k] = err_ff[k] + ERR_W'(cnt_ff[k]);
      end
      if (cmd.load) begin
         n_in   = ld_max;
         idx_in = '0;
         dir_in = req_tdata[3*CNT_W +: 3];
         for (int k = 0; k < 3; k++) begin
            cnt_in[k] = ld_cnt[k];
            err_in[k] = '0;
         end
      end else if (cmd.start) begin
         idx_in  = idx_nxt;
         last_in = (idx_nxt == n_ff);
         for (int k = 0; k < 3; k++) begin
            if (err_sum[k] >= ERR_W'(n_ff)) begin
               step_in[k] = 1'b1;
               err_in[k]  = err_sum[k] - ERR_W'(n_ff);
            end else begin
               step_in[k] = 1'b0;
               err_in[k]  = err_sum[k];
            end
         end
      end
   end

   // Products, one multiplier per register
   always_comb begin
      p_in   = p_ff;
      nsq_in = nsq_ff;
      gp_in  = gp_ff;
      if (cmd.mul_p) begin
         p_in   = PROD_W'(idx_ff) * PROD_W'(n_ff - idx_ff);
         nsq_in = PROD_W'(n_ff) * PROD_W'(n_ff);
      end
      if (cmd.mul_g) begin
         gp_in = GP_W'(gain_ff) * GP_W'(p_ff);
      end
   end

   // Restoring divider, one quotient bit per cycle; quotient fits QUO_W bits
   assign rem_ge = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (cmd.div_init) begin
         quo_in = '0;
         if (n_ff <= limit_ff) begin
            rem_in = DIV_W'(p_ff);
            dsh_in = DIV_W'(n_ff) << (QUO_W - 1);
         end else begin
            rem_in = DIV_W'(gp_ff);
            dsh_in = DIV_W'(nsq_ff) << (QUO_W - 1);
         end
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[QUO_W-2:0], rem_ge};
         dsh_in = dsh_ff >> 1;
      end
   end

   // Ceiling of the quotient, then saturating subtract from the base
   assign dip = DIP_W'(quo_ff) + DIP_W'(rem_ff != '0);
   assign hp  = (dip >= DIP_W'(base_ff)) ? '0 : base_ff - HP_W'(dip);

   always_comb begin
      out_in   = out_ff;
      olast_in = olast_ff;
      if (cmd.out_load) begin
         out_in   = RSP_DATA_W'({hp, dir_ff, step_ff});
         olast_in = last_ff;
      end
   end

   assign rsp_tdata = out_ff;
   assign rsp_tlast = olast_ff;

endmodule

// File: rtl/three_axis_step_interpolator.sv
// Three-axis step interpolator: exact integer DDA with parabolic pacing.
// req channel: tuser = kind (0 load a move, 1 advance one major step).
//   A load item latches three axis counts and directions and gives no
//   result. A step item with a move pending gives one
//   rsp item with the axis pulses, directions and the half period; a step
//   item with no move pending is taken and dropped.
// rsp channel: tlast marks the final step of the move.
// A step result passes through ST_MUL_P and ST_MUL_G, ST_DIV_SETUP, the
//   bit-serial divider in ST_DIV and then ST_HOLD, which loads the output
//   register. One step item is in work at a time; no new item is taken until
//   its result is in the output register. Loads run at one per cycle while idle.
// The output register lets the next item be taken while a result waits;
//   if rsp_tready stays low, the following step holds its result inside
//   and req_tready stays low until the output register frees.
// Reset (synchronous) returns the registers to their defaults and clears
//   the move, so step items give nothing until a load.
// csr port: a write lands at the clock edge where csr_we is high.
module three_axis_step_interpolator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // count_x, count_y, count_z, dir_x_in, dir_y_in, dir_z_in, zero pad
   input  logic [tasi_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // step_x, step_y, step_z, dir_x, dir_y, dir_z, half_period_us, zero pad
   output logic [tasi_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [tasi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tasi_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tasi_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tasi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   tasi_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: sim/testbench.sv
module testbench;
   import tasi_pkg::*;

   // Index with no register behind it; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 30;      // idle wait, longer than a step result takes
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct {
      logic [2:0]      pulse;
      logic [2:0]      dir;
      logic [HP_W-1:0] half_period;
      logic            last;
   } step_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // count_x, count_y, count_z, dir_x_in, dir_y_in, dir_z_in, zero pad
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // cmd
   logic req_tuser = CMD_LOAD;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // step_x, step_y, step_z, dir_x, dir_y, dir_z, half_period_us, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   three_axis_step_interpolator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor copy of the registers and the move in progress
   longint unsigned base_hp = BASE_RESET;
   longint unsigned move_limit = LIMIT_RESET;
   longint unsigned dip_gain = GAIN_RESET;
   longint unsigned move_len = 0;
   longint unsigned step_idx = 0;
   longint unsigned axis_cnt [3] = '{0, 0, 0};
   longint unsigned taken [3] = '{0, 0, 0};
   logic [2:0] axis_dir = '0;

   step_result_type step_results_due [$];
   int mismatches = 0;
   int items_sent = 0;
   int steps_checked = 0;
   int reg_writes = 0;
   int long_steps = 0;
   int cycles = 0;
   bit steady = 0;

   // Advance the predictor by one accepted item; a step with a move pending
   // queues one expected result
   function automatic void interpolate(logic cmd, logic [2:0][15:0] counts, logic [2:0] dirs);
      step_result_type r;
      longint unsigned i, n, p, dip;
      if (cmd == CMD_LOAD) begin
         move_len = 0;
         for (int k = 0; k < 3; k++) begin
            axis_cnt[k] = counts[k];
            axis_dir[k] = dirs[k];
            taken[k] = 0;
            if (axis_cnt[k] > move_len) move_len = axis_cnt[k];
         end
         step_idx = 0;
         return;
      end
      if (step_idx >= move_len) return;
      step_idx++;
      i = step_idx;
      n = move_len;
      for (int k = 0; k < 3; k++) begin
         r.pulse[k] = (i * axis_cnt[k] >= (taken[k] + 1) * n);
         if (r.pulse[k]) taken[k] = (taken[k] + 1) & 16'hFFFF;
         r.dir[k] = axis_dir[k];
      end
      p = i * (n - i);
      if (n <= move_limit) begin
         dip = (p + n - 1) / n;
      end else begin
         dip = (dip_gain * p + n * n - 1) / (n * n);
         long_steps++;
      end
      r.half_period = (dip >= base_hp) ? '0 : HP_W'(base_hp - dip);
      r.last = (i == n);
      step_results_due.push_back(r);
   endfunction

   // Mostly short gaps, a few long ones, none in steady stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("MISMATCH at %0t, result %0d, %s: got %0h, want %0h",
               $time, steps_checked, field, got, want);
      mismatches++;
   endtask

   // Result checker
   always @(posedge clock) begin
      step_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (step_results_due.size() == 0) begin
            report_mismatch("result with no step due", rsp_tdata, 0);
         end else begin
            want = step_results_due.pop_front();
            for (int k = 0; k < 3; k++) begin
               if (rsp_tdata[k] !== want.pulse[k])
                  report_mismatch($sformatf("step of axis %0d", k), rsp_tdata[k], want.pulse[k]);
               if (rsp_tdata[3+k] !== want.dir[k])
                  report_mismatch($sformatf("dir of axis %0d", k), rsp_tdata[3+k], want.dir[k]);
            end
            if (rsp_tdata[21:6] !== want.half_period)
               report_mismatch("half_period_us", rsp_tdata[21:6], want.half_period);
            if (rsp_tlast !== want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
         steps_checked++;
      end
   end

   // Receiver stalls
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_item(input logic cmd, input logic [2:0][15:0] counts, input logic [2:0] dirs);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {5'b0, dirs, counts};
      do @(posedge clock); while (!req_tready);
      interpolate(cmd, counts, dirs);
      items_sent++;
   endtask

   task automatic load_move(input logic [2:0][15:0] counts, input logic [2:0] dirs);
      send_item(CMD_LOAD, counts, dirs);
   endtask

   // Step items carry random data that the block must ignore
   task automatic step_once();
      logic [2:0][15:0] junk;
      for (int k = 0; k < 3; k++) junk[k] = 16'($urandom_range(0, 65535));
      send_item(CMD_STEP, junk, 3'($urandom_range(0, 7)));
   endtask

   // Register write, only once the block has drained
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (step_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BASE:  base_hp = value;
         CSR_LIMIT: move_limit = value;
         CSR_GAIN:  dip_gain = value[GAIN_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic set_config(input logic [15:0] base, input logic [15:0] limit,
                             input logic [15:0] gain_word);
      write_reg(CSR_BASE, base);
      write_reg(CSR_LIMIT, limit);
      write_reg(CSR_GAIN, gain_word);
   endtask

   // Steps before any load, then after an all-zero load: nothing comes back
   task automatic test_no_move_pending();
      step_once();
      load_move('{16'd0, 16'd0, 16'd0}, 3'b111);
      step_once();
      step_once();
   endtask

   // Small move with one idle axis, one extra step past the end
   task automatic test_short_move();
      load_move('{16'd0, 16'd2, 16'd3}, 3'b101);
      repeat (4) step_once();
   endtask

   // Full-scale counts, broken off by a one-step move
   task automatic test_reload_mid_move();
      load_move('{16'hFFFF, 16'hFFFF, 16'hFFFF}, 3'b111);
      repeat (3) step_once();
      load_move('{16'd0, 16'd0, 16'd1}, 3'b010);
      repeat (2) step_once();
   endtask

   // Long-move profile with the gain above its range and upper bits masked
   task automatic test_long_moves();
      set_config(16'hFFFF, 16'd4, 16'hFFFF);
      load_move('{16'd3, 16'd7, 16'd10}, 3'b011);
      repeat (10) step_once();
      set_config(16'd1000, 16'd0, 16'hAFA0);
      load_move('{16'd9, 16'd1, 16'd5}, 3'b100);
      repeat (9) step_once();
   endtask

   // Base below the dip saturates; zero gain and zero base
   task automatic test_saturation();
      set_config(16'd3, 16'hFFFF, 16'd0);
      load_move('{16'd20, 16'd13, 16'd19}, 3'b110);
      repeat (20) step_once();
      set_config(16'd0, 16'd0, 16'd0);
      load_move('{16'd4, 16'd6, 16'd2}, 3'b001);
      repeat (6) step_once();
   endtask

   // A write to the spare index leaves every register as it was
   task automatic test_spare_index();
      set_config(16'd500, 16'd6, 16'd3000);
      write_reg(CSR_SPARE, 16'h0001);
      load_move('{16'd12, 16'd5, 16'd8}, 3'b010);
      repeat (12) step_once();
   endtask

   task automatic random_config();
      logic [15:0] base, limit, gain_word;
      case ($urandom_range(0, 3))
         0: base = 16'd0;
         1: base = 16'hFFFF;
         2: base = BASE_RESET;
         default: base = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 4))
         0: limit = 16'd0;
         1: limit = 16'hFFFF;
         default: limit = 16'($urandom_range(0, 80));
      endcase
      gain_word = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
         0: gain_word[11:0] = 12'd0;
         1: gain_word[11:0] = 12'hFFF;
         default: ;
      endcase
      set_config(base, limit, gain_word);
      if ($urandom_range(0, 3) == 0) write_reg(CSR_SPARE, 16'($urandom_range(0, 65535)));
   endtask

   // Mostly complete moves, some broken off or overrun, some random full-range
   // counts stepped briefly, and some noise
   task automatic test_random_moves(input int target);
      int first, next_cfg, nmax, nsteps, r;
      logic [2:0][15:0] cnt;
      first = items_sent;
      next_cfg = items_sent;
      while (items_sent - first < target) begin
         if (items_sent >= next_cfg) begin
            random_config();
            steady = ($urandom_range(0, 3) == 0);
            next_cfg = items_sent + $urandom_range(100, 200);
         end
         r = $urandom_range(0, 9);
         if (r < 7) begin
            nmax = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
            for (int k = 0; k < 3; k++) cnt[k] = 16'($urandom_range(0, nmax));
            cnt[$urandom_range(0, 2)] = 16'(nmax);
            load_move(cnt, 3'($urandom_range(0, 7)));
            nsteps = nmax;
            r = $urandom_range(0, 9);
            if (r == 0) nsteps = $urandom_range(0, nmax - 1);
            else if (r == 1) nsteps = nsteps + $urandom_range(1, 2);
            repeat (nsteps) step_once();
         end else if (r < 9) begin
            for (int k = 0; k < 3; k++) cnt[k] = 16'($urandom_range(0, 65535));
            load_move(cnt, 3'($urandom_range(0, 7)));
            repeat ($urandom_range(1, 4)) step_once();
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 2) != 0) begin
                  step_once();
               end else begin
                  for (int k = 0; k < 3; k++) cnt[k] = 16'($urandom_range(0, 65535));
                  load_move(cnt, 3'($urandom_range(0, 7)));
               end
            end
         end
      end
      steady = 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_no_move_pending();
      test_short_move();
      test_reload_mid_move();
      test_long_moves();
      test_saturation();
      test_spare_index();
      test_random_moves(1550);

      // Drain
      req_tvalid <= 1'b0;
      while (step_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (step_results_due.size() != 0) begin
         report_mismatch("step result never came", step_results_due.size(), 0);
         void'(step_results_due.pop_front());
      end

      $display("Sent %0d items, checked %0d step results (%0d on the long-move profile)",
               items_sent, steps_checked, long_steps);
      $display("Made %0d register writes across base, limit, gain and the spare index",
               reg_writes);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/tasi_pkg.sv
rtl/tasi_ctrl.sv
rtl/tasi_dp.sv
rtl/three_axis_step_interpolator.sv
sim/testbench.sv
